>>> design/mcop_pkg.sv
// ----------------------------------------------------------------------------
// mcop_pkg
// Shared types and constants of the chunk offset patcher.
// ----------------------------------------------------------------------------
package mcop_pkg;

  // Atom type tags.
  localparam logic [31:0] TagStco = 32'h7374_636f;
  localparam logic [31:0] TagCo64 = 32'h636f_3634;
  localparam logic [31:0] TagMoov = 32'h6d6f_6f76;
  localparam logic [31:0] TagTrak = 32'h7472_616b;
  localparam logic [31:0] TagMdia = 32'h6d64_6961;
  localparam logic [31:0] TagMinf = 32'h6d69_6e66;
  localparam logic [31:0] TagStbl = 32'h7374_626c;

  // Length of a short atom header in bytes.
  localparam int unsigned HdrLen = 8;

  // Depth of the queue between parser and serializer.
  localparam int unsigned QDepth = 4;

  // Error codes.
  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrLongSize = 3'd1;
  localparam logic [2:0] ErrSmall    = 3'd2;
  localparam logic [2:0] ErrBig      = 3'd3;
  localparam logic [2:0] ErrTable    = 3'd4;
  localparam logic [2:0] ErrCount    = 3'd5;
  localparam logic [2:0] ErrNest     = 3'd6;

  // Register indexes.
  localparam logic RegOffsetAdd = 1'b0;
  localparam logic RegBufLen    = 1'b1;

  // Parser phases.
  typedef enum logic [7:0] {
    PhHdr     = 8'b0000_0001,
    PhLong    = 8'b0000_0010,
    PhSkip    = 8'b0000_0100,
    PhStcoHd  = 8'b0000_1000,
    PhCo64Hd  = 8'b0001_0000,
    PhStcoEnt = 8'b0010_0000,
    PhCo64Ent = 8'b0100_0000,
    PhHalt    = 8'b1000_0000
  } phase_e;

  // A group of output bytes caused by one input word, first byte on top.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
    logic [2:0]  err;
    logic        ovf;
  } group_t;

endpackage

>>> design/mcop_if.sv
// ----------------------------------------------------------------------------
// mcop_if
// Stream channels of the chunk offset patcher.
// ----------------------------------------------------------------------------
interface mcop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source(output valid, in_byte, in_last, input ready);
  modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface mcop_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [2:0] error_code;
  logic       overflow_flag;
  modport source(output valid, out_byte, out_last, error_code, overflow_flag, input ready);
  modport sink(input valid, out_byte, out_last, error_code, overflow_flag, output ready);
endinterface

>>> design/mcop_front.sv
// ----------------------------------------------------------------------------
// mcop_front
// Atom parser: one word a cycle unless the queue is full; emits byte groups.
// ----------------------------------------------------------------------------
module mcop_front #(
  parameter int unsigned MAX_NEST = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mcop_in_if.sink           in_ch,
  input  logic              full_i,
  input  logic [31:0]       offset_i,
  input  logic [31:0]       buflen_i,
  output logic              push_o,
  output mcop_pkg::group_t  grp_o
);

  localparam int unsigned NW = $clog2(MAX_NEST + 1);

  logic [31:0]      lev_q [MAX_NEST+1];
  logic [31:0]      lev_d [MAX_NEST+1];
  logic [NW-1:0]    nest_q, nest_d;
  logic [63:0]      hdr0_q, hdr0_d, hdr1_q, hdr1_d;
  mcop_pkg::phase_e phase_q, phase_d;
  logic [31:0]      atom_q, atom_d, cnt_q, cnt_d;
  logic [63:0]      acc_q, acc_d;
  logic [2:0]       idx_q, idx_d, err_q, err_d;
  logic             ovf_q, ovf_d, open_q, open_d;
  logic             take;

  function automatic logic [2:0] first_err(logic [2:0] cur, logic [2:0] code);
    return (cur == mcop_pkg::ErrNone) ? code : cur;
  endfunction

  assign in_ch.ready = !full_i;
  assign take = in_ch.valid && !full_i;

  // Next-state logic of the parser for one accepted word.
  always_comb begin
    logic [31:0]   rem;
    logic [63:0]   fsize, fbody;
    logic [63:0]   fhsize;
    logic [31:0]   ftype;
    logic          fen, ftoend, fok;
    logic [32:0]   s32;
    logic [63:0]   s64;
    logic [31:0]   lim;
    logic [NW-1:0] topl;
    logic [7:0]    b;
    lev_d   = lev_q;
    nest_d  = nest_q;
    hdr0_d  = hdr0_q;
    hdr1_d  = hdr1_q;
    phase_d = phase_q;
    atom_d  = atom_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    idx_d   = idx_q;
    err_d   = err_q;
    ovf_d   = ovf_q;
    open_d  = open_q;
    push_o  = 1'b0;
    grp_o   = '0;
    fen     = 1'b0;
    ftoend  = 1'b0;
    fok     = 1'b1;
    fsize   = '0;
    fbody   = '0;
    fhsize  = 64'(mcop_pkg::HdrLen);
    ftype   = '0;
    s32     = '0;
    s64     = '0;
    lim     = '0;
    topl    = '0;
    rem     = '0;
    b       = in_ch.in_byte;
    if (take) begin
      // A new buffer starts from a clean parser.
      if (!open_q) begin
        lev_d[0] = buflen_i;
        nest_d   = '0;
        hdr0_d   = '0;
        hdr1_d   = '0;
        phase_d  = mcop_pkg::PhHdr;
        atom_d   = '0;
        cnt_d    = '0;
        acc_d    = '0;
        idx_d    = '0;
        err_d    = '0;
        ovf_d    = 1'b0;
        open_d   = 1'b1;
      end
      grp_o.data = {b, 56'b0};
      grp_o.cnt  = 4'd1;
      case (phase_d)
        mcop_pkg::PhHdr: begin
          rem = lev_d[nest_d];
          if (idx_d == 3'd0 && rem < 32'(mcop_pkg::HdrLen)) begin
            if (rem != 32'd0) lev_d[nest_d] = rem - 32'd1;
          end else begin
            hdr0_d = {hdr0_d[55:0], b};
            lev_d[nest_d] = rem - 32'd1;
            if (idx_d == 3'd7) begin
              idx_d = '0;
              if (hdr0_d[63:32] == 32'd1) begin
                if (lev_d[nest_d] < 32'(mcop_pkg::HdrLen)) begin
                  err_d   = first_err(err_d, mcop_pkg::ErrLongSize);
                  phase_d = mcop_pkg::PhHalt;
                  idx_d   = '0;
                end else begin
                  hdr1_d  = '0;
                  phase_d = mcop_pkg::PhLong;
                end
              end else begin
                fen    = 1'b1;
                fsize  = {32'b0, hdr0_d[63:32]};
                ftype  = hdr0_d[31:0];
                ftoend = (hdr0_d[63:32] == 32'd0);
              end
            end else begin
              idx_d = idx_d + 3'd1;
            end
          end
        end
        mcop_pkg::PhLong: begin
          hdr1_d = {hdr1_d[55:0], b};
          if (lev_d[nest_d] != 32'd0) lev_d[nest_d] = lev_d[nest_d] - 32'd1;
          if (idx_d == 3'd7) begin
            idx_d  = '0;
            fen    = 1'b1;
            fsize  = hdr1_d;
            fhsize = 64'(2 * mcop_pkg::HdrLen);
            ftype  = hdr0_d[31:0];
          end else begin
            idx_d = idx_d + 3'd1;
          end
        end
        mcop_pkg::PhSkip: begin
          if (atom_d != 32'd0) atom_d = atom_d - 32'd1;
          if (atom_d == 32'd0) phase_d = mcop_pkg::PhHdr;
        end
        mcop_pkg::PhStcoHd, mcop_pkg::PhCo64Hd: begin
          acc_d = {acc_d[55:0], b};
          if (atom_d != 32'd0) atom_d = atom_d - 32'd1;
          if (idx_d == 3'd7) begin
            lim   = (phase_d == mcop_pkg::PhStcoHd) ? (atom_d >> 2) : (atom_d >> 3);
            idx_d = '0;
            if (acc_d[31:0] > lim) begin
              err_d   = first_err(err_d, mcop_pkg::ErrCount);
              phase_d = mcop_pkg::PhHalt;
            end else begin
              cnt_d = acc_d[31:0];
              if (acc_d[31:0] != 32'd0) begin
                phase_d = (phase_d == mcop_pkg::PhStcoHd) ? mcop_pkg::PhStcoEnt
                                                          : mcop_pkg::PhCo64Ent;
              end else begin
                phase_d = (atom_d != 32'd0) ? mcop_pkg::PhSkip : mcop_pkg::PhHdr;
              end
            end
            acc_d = '0;
          end else begin
            idx_d = idx_d + 3'd1;
          end
        end
        mcop_pkg::PhStcoEnt, mcop_pkg::PhCo64Ent: begin
          acc_d = {acc_d[55:0], b};
          if (atom_d != 32'd0) atom_d = atom_d - 32'd1;
          grp_o.cnt = 4'd0;
          if ((phase_d == mcop_pkg::PhStcoEnt && idx_d == 3'd3) || idx_d == 3'd7) begin
            if (phase_d == mcop_pkg::PhStcoEnt) begin
              s32 = {1'b0, acc_d[31:0]} + {1'b0, offset_i};
              if (s32[32]) ovf_d = 1'b1;
              grp_o.data = {s32[31:0], 32'b0};
              grp_o.cnt  = 4'd4;
            end else begin
              s64 = acc_d + {32'b0, offset_i};
              grp_o.data = s64;
              grp_o.cnt  = 4'd8;
            end
            acc_d = '0;
            idx_d = '0;
            if (cnt_d != 32'd0) cnt_d = cnt_d - 32'd1;
            if (cnt_d == 32'd0) begin
              phase_d = (atom_d != 32'd0) ? mcop_pkg::PhSkip : mcop_pkg::PhHdr;
            end
          end else begin
            idx_d = idx_d + 3'd1;
          end
        end
        default: begin
        end
      endcase

      // Completion of an atom header.
      if (fen) begin
        rem = lev_d[nest_d];
        if (ftoend) begin
          fbody = {32'b0, rem};
        end else if (fsize < fhsize) begin
          err_d   = first_err(err_d, mcop_pkg::ErrSmall);
          phase_d = mcop_pkg::PhHalt;
          idx_d   = '0;
          fok     = 1'b0;
        end else begin
          fbody = fsize - fhsize;
          if (fbody > {32'b0, rem}) begin
            err_d   = first_err(err_d, mcop_pkg::ErrBig);
            phase_d = mcop_pkg::PhHalt;
            idx_d   = '0;
            fok     = 1'b0;
          end
        end
        if (fok) begin
          lev_d[nest_d] = rem - fbody[31:0];
          if (ftype == mcop_pkg::TagStco || ftype == mcop_pkg::TagCo64) begin
            if (fbody[31:0] < 32'(mcop_pkg::HdrLen)) begin
              err_d   = first_err(err_d, mcop_pkg::ErrTable);
              phase_d = mcop_pkg::PhHalt;
            end else begin
              atom_d  = fbody[31:0];
              acc_d   = '0;
              phase_d = (ftype == mcop_pkg::TagStco) ? mcop_pkg::PhStcoHd
                                                     : mcop_pkg::PhCo64Hd;
            end
            idx_d = '0;
          end else if (ftype == mcop_pkg::TagMoov || ftype == mcop_pkg::TagTrak ||
                       ftype == mcop_pkg::TagMdia || ftype == mcop_pkg::TagMinf ||
                       ftype == mcop_pkg::TagStbl) begin
            if (nest_d == NW'(MAX_NEST)) begin
              err_d   = first_err(err_d, mcop_pkg::ErrNest);
              phase_d = mcop_pkg::PhHalt;
            end else begin
              lev_d[nest_d + NW'(1)] = fbody[31:0];
              nest_d  = nest_d + NW'(1);
              phase_d = mcop_pkg::PhHdr;
            end
            idx_d = '0;
          end else begin
            atom_d  = fbody[31:0];
            phase_d = (fbody[31:0] != 32'd0) ? mcop_pkg::PhSkip : mcop_pkg::PhHdr;
            idx_d   = '0;
          end
        end
      end

      // Leave every exhausted container level.
      if (phase_d == mcop_pkg::PhHdr && idx_d == 3'd0) begin
        for (int j = 1; j <= int'(MAX_NEST); j++) begin
          if (NW'(j) <= nest_d && lev_d[j] != 32'd0) topl = NW'(j);
        end
        nest_d = topl;
      end

      // An early end flushes a partly collected entry unpatched.
      if (in_ch.in_last) begin
        if (grp_o.cnt == 4'd0) begin
          grp_o.data = acc_d << {(4'd8 - {1'b0, idx_d}), 3'b000};
          grp_o.cnt  = {1'b0, idx_d};
        end
        open_d = 1'b0;
      end
      grp_o.last = in_ch.in_last;
      grp_o.err  = err_d;
      grp_o.ovf  = ovf_d;
      push_o     = (grp_o.cnt != 4'd0);
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= int'(MAX_NEST); j++) lev_q[j] <= '0;
      nest_q  <= '0;
      hdr0_q  <= '0;
      hdr1_q  <= '0;
      phase_q <= mcop_pkg::PhHdr;
      atom_q  <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
      idx_q   <= '0;
      err_q   <= '0;
      ovf_q   <= 1'b0;
      open_q  <= 1'b0;
    end else begin
      lev_q   <= lev_d;
      nest_q  <= nest_d;
      hdr0_q  <= hdr0_d;
      hdr1_q  <= hdr1_d;
      phase_q <= phase_d;
      atom_q  <= atom_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      idx_q   <= idx_d;
      err_q   <= err_d;
      ovf_q   <= ovf_d;
      open_q  <= open_d;
    end
  end

endmodule

>>> design/mcop_queue.sv
// ----------------------------------------------------------------------------
// mcop_queue
// Short queue of byte groups between the parser and the serializer.
// ----------------------------------------------------------------------------
module mcop_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mcop_pkg::group_t  wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              avail_o,
  output mcop_pkg::group_t  rdata_o
);

  localparam int unsigned PW = $clog2(mcop_pkg::QDepth);

  mcop_pkg::group_t slot_q [mcop_pkg::QDepth];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [PW:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(mcop_pkg::QDepth));
  assign avail_o = (cnt_q != '0);
  assign rdata_o = slot_q[rp_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wp_d  = push_i ? wp_q + PW'(1) : wp_q;
    rp_d  = pop_i ? rp_q + PW'(1) : rp_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= wdata_i;
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o) else $error("queue read while empty");
  a_group_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (wdata_i.cnt != 4'd0 && wdata_i.cnt <= 4'd8))
    else $error("pushed group has a bad byte count");
`endif

endmodule

>>> design/mcop_back.sv
// ----------------------------------------------------------------------------
// mcop_back
// Serializer: sends the bytes of each queued group one word at a time.
// ----------------------------------------------------------------------------
module mcop_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  mcop_pkg::group_t  head_i,
  output logic              pop_o,
  mcop_out_if.source        out_ch
);

  mcop_pkg::group_t g_q, g_d;
  logic             busy, take;

  assign busy = (g_q.cnt != 4'd0);
  assign take = busy && out_ch.ready;

  assign out_ch.valid         = busy;
  assign out_ch.out_byte      = g_q.data[63:56];
  assign out_ch.out_last      = g_q.last && (g_q.cnt == 4'd1);
  assign out_ch.error_code    = g_q.err;
  assign out_ch.overflow_flag = g_q.ovf;

  // Load the next group once the current one is drained.
  always_comb begin
    g_d   = g_q;
    pop_o = 1'b0;
    if (!busy || (take && g_q.cnt == 4'd1)) begin
      if (avail_i) begin
        g_d   = head_i;
        pop_o = 1'b1;
      end else begin
        g_d.cnt = 4'd0;
      end
    end else if (take) begin
      g_d.data = {g_q.data[55:0], 8'b0};
      g_d.cnt  = g_q.cnt - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q <= '0;
    end else begin
      g_q <= g_d;
    end
  end

endmodule

>>> design/movie_chunk_offset_patcher_unit.sv
// A passed byte goes through a queue slot and the serializer register; a
// patched entry does so after its last byte, then one byte per cycle while
// the output is ready. Input: one word a cycle unless the queue is full.
// Reset: asynchronous, active low; clears parser, queue and serializer.
// Registers reset to zero, but the parser phase resets to PhHdr.
// ----------------------------------------------------------------------------
// movie_chunk_offset_patcher_unit
// Parses movie metadata atoms and adds an offset to chunk offset tables.
// ----------------------------------------------------------------------------
module movie_chunk_offset_patcher_unit #(
  parameter int unsigned MAX_NEST = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcop_in_if.sink     in_ch,
  mcop_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]      offset_q, buflen_q;
  logic             wr;
  logic             full, push, pop, avail;
  mcop_pkg::group_t wgrp, hgrp;

  // Configuration port.
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign prdata = (paddr[2] == mcop_pkg::RegBufLen) ? buflen_q : offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      buflen_q <= '0;
    end else if (wr) begin
      if (paddr[2] == mcop_pkg::RegOffsetAdd) offset_q <= pwdata;
      else buflen_q <= pwdata;
    end
  end

  mcop_front #(.MAX_NEST(MAX_NEST)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .full_i   (full),
    .offset_i (offset_q),
    .buflen_i (buflen_q),
    .push_o   (push),
    .grp_o    (wgrp)
  );

  mcop_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wgrp),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .rdata_o (hgrp)
  );

  mcop_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .head_i  (hgrp),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

>>> tb/sv/tb_movie_chunk_offset_patcher_unit.sv
// ----------------------------------------------------------------------------
// tb_movie_chunk_offset_patcher_unit
// Feeds metadata buffers byte by byte, from hand-built atom trees, error
// cases and random trees, and checks every output word against a built-in
// model of the atom parser and the chunk offset patch.
// ----------------------------------------------------------------------------
module tb_movie_chunk_offset_patcher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] bytes_t[$];

  // One output word as the model expects it.
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [2:0] err;
    logic       ovf;
  } out_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mcop_in_if  in_ch ();
  mcop_out_if out_ch ();

  movie_chunk_offset_patcher_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  localparam int unsigned NestMax = 10;

  always #5 clk_i = ~clk_i;

  out_word_t   patched_words[$];
  int unsigned mismatches = 0;
  int unsigned sent_total = 0;
  bit          no_idle = 1'b0;

  // Model state: configuration and parser.
  logic [31:0]      m_offset;
  logic [31:0]      m_buflen;
  logic [63:0]      m_level[NestMax+1];
  int unsigned      m_nest;
  logic [63:0]      m_hdr0, m_hdr1;
  mcop_pkg::phase_e m_phase;
  logic [63:0]      m_atom;
  logic [31:0]      m_count;
  logic [63:0]      m_acc;
  int unsigned      m_idx;
  logic [2:0]       m_err;
  logic             m_ovf;
  bit               m_open;

  function automatic void parser_fail(logic [2:0] code);
    if (m_err == mcop_pkg::ErrNone) m_err = code;
    m_phase = mcop_pkg::PhHalt;
    m_idx = 0;
  endfunction

  function automatic void body_finished();
    m_phase = (m_atom != 0) ? mcop_pkg::PhSkip : mcop_pkg::PhHdr;
    m_idx = 0;
  endfunction

  function automatic void header_done(logic [63:0] size, logic [63:0] hsize,
                                      logic [31:0] tag, bit to_end);
    int unsigned lv;
    logic [63:0] rem, body;
    lv = m_nest;
    rem = m_level[lv];
    if (to_end) begin
      body = rem;
    end else begin
      if (size < hsize) begin
        parser_fail(mcop_pkg::ErrSmall);
        return;
      end
      body = size - hsize;
      if (body > rem) begin
        parser_fail(mcop_pkg::ErrBig);
        return;
      end
    end
    m_level[lv] = rem - body;
    if (tag == mcop_pkg::TagStco || tag == mcop_pkg::TagCo64) begin
      if (body < 8) begin
        parser_fail(mcop_pkg::ErrTable);
        return;
      end
      m_atom = body;
      m_acc = '0;
      m_idx = 0;
      m_phase = (tag == mcop_pkg::TagStco) ? mcop_pkg::PhStcoHd : mcop_pkg::PhCo64Hd;
    end else if (tag == mcop_pkg::TagMoov || tag == mcop_pkg::TagTrak ||
                 tag == mcop_pkg::TagMdia || tag == mcop_pkg::TagMinf ||
                 tag == mcop_pkg::TagStbl) begin
      if (lv + 1 > NestMax) begin
        parser_fail(mcop_pkg::ErrNest);
        return;
      end
      m_nest = lv + 1;
      m_level[lv+1] = body;
      m_phase = mcop_pkg::PhHdr;
      m_idx = 0;
    end else begin
      m_atom = body;
      body_finished();
    end
  endfunction

  // Advances the model by one accepted byte and queues the words it causes.
  function automatic void predict_patch(logic [7:0] b, logic last);
    bytes_t      outs;
    logic [63:0] rem, v;
    logic [31:0] cnt;
    int unsigned lv, esz;
    bit          narrow;
    out_word_t   w;
    if (!m_open) begin
      foreach (m_level[i]) m_level[i] = '0;
      m_level[0] = {32'b0, m_buflen};
      m_nest = 0; m_hdr0 = '0; m_hdr1 = '0; m_phase = mcop_pkg::PhHdr; m_atom = '0;
      m_count = '0; m_acc = '0; m_idx = 0; m_err = mcop_pkg::ErrNone; m_ovf = 1'b0;
      m_open = 1'b1;
    end
    case (m_phase)
      mcop_pkg::PhHdr: begin
        lv = m_nest;
        rem = m_level[lv];
        outs.push_back(b);
        if (m_idx == 0 && rem < mcop_pkg::HdrLen) begin
          // Short tail of a level: passes unparsed.
          if (rem > 0) m_level[lv] = rem - 1;
        end else begin
          m_hdr0 = {m_hdr0[55:0], b};
          m_level[lv] = rem - 1;
          if (m_idx == 7) begin
            m_idx = 0;
            if (m_hdr0[63:32] == 32'd1) begin
              if (m_level[lv] < 8) parser_fail(mcop_pkg::ErrLongSize);
              else begin
                m_hdr1 = '0;
                m_phase = mcop_pkg::PhLong;
              end
            end else begin
              header_done({32'b0, m_hdr0[63:32]}, mcop_pkg::HdrLen, m_hdr0[31:0],
                          m_hdr0[63:32] == 0);
            end
          end else m_idx++;
        end
      end
      mcop_pkg::PhLong: begin
        outs.push_back(b);
        m_hdr1 = {m_hdr1[55:0], b};
        if (m_level[m_nest] > 0) m_level[m_nest]--;
        if (m_idx == 7) begin
          m_idx = 0;
          header_done(m_hdr1, 2 * mcop_pkg::HdrLen, m_hdr0[31:0], 1'b0);
        end else m_idx++;
      end
      mcop_pkg::PhSkip: begin
        outs.push_back(b);
        if (m_atom > 0) m_atom--;
        if (m_atom == 0) m_phase = mcop_pkg::PhHdr;
      end
      mcop_pkg::PhStcoHd, mcop_pkg::PhCo64Hd: begin
        outs.push_back(b);
        m_acc = {m_acc[55:0], b};
        if (m_atom > 0) m_atom--;
        if (m_idx == 7) begin
          cnt = m_acc[31:0];
          narrow = (m_phase == mcop_pkg::PhStcoHd);
          m_idx = 0;
          m_acc = '0;
          if ({32'b0, cnt} > m_atom / (narrow ? 4 : 8)) parser_fail(mcop_pkg::ErrCount);
          else begin
            m_count = cnt;
            if (cnt > 0) m_phase = narrow ? mcop_pkg::PhStcoEnt : mcop_pkg::PhCo64Ent;
            else body_finished();
          end
        end else m_idx++;
      end
      mcop_pkg::PhStcoEnt, mcop_pkg::PhCo64Ent: begin
        esz = (m_phase == mcop_pkg::PhStcoEnt) ? 4 : 8;
        m_acc = {m_acc[55:0], b};
        if (m_atom > 0) m_atom--;
        if (m_idx + 1 >= esz) begin
          if (esz == 4) begin
            v = {32'b0, m_acc[31:0]} + {32'b0, m_offset};
            if (v[32]) m_ovf = 1'b1;
            v[63:32] = '0;
          end else v = m_acc + {32'b0, m_offset};
          for (int k = esz - 1; k >= 0; k--) outs.push_back(v[8*k +: 8]);
          m_acc = '0;
          m_idx = 0;
          if (m_count > 0) m_count--;
          if (m_count == 0) body_finished();
        end else m_idx++;
      end
      default: outs.push_back(b);
    endcase
    // Close every level that has been consumed.
    if (m_phase == mcop_pkg::PhHdr && m_idx == 0)
      while (m_nest > 0 && m_level[m_nest] == 0) m_nest--;
    if (last) begin
      // An entry cut short by the end of the buffer leaves unpatched.
      if (outs.size() == 0)
        for (int k = m_idx - 1; k >= 0 && outs.size() < 8; k--)
          outs.push_back(m_acc[8*k +: 8]);
      m_open = 1'b0;
    end
    foreach (outs[k]) begin
      w.data = outs[k];
      w.last = last && (k == outs.size() - 1);
      w.err = m_err;
      w.ovf = m_ovf;
      patched_words.push_back(w);
    end
  endfunction

  // Output side: random back-pressure, and each word compared with the oldest.
  always @(posedge clk_i) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 30);
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (patched_words.size() == 0) begin
        $display("%0t: unexpected word: byte %h last %b err %0d ovf %b", $time,
                 out_ch.out_byte, out_ch.out_last, out_ch.error_code,
                 out_ch.overflow_flag);
        mismatches++;
      end else begin
        out_word_t w;
        w = patched_words.pop_front();
        if (out_ch.out_byte !== w.data || out_ch.out_last !== w.last ||
            out_ch.error_code !== w.err || out_ch.overflow_flag !== w.ovf) begin
          $display("%0t: expected byte %h last %b err %0d ovf %b, got %h %b %0d %b",
                   $time, w.data, w.last, w.err, w.ovf, out_ch.out_byte,
                   out_ch.out_last, out_ch.error_code, out_ch.overflow_flag);
          mismatches++;
        end
      end
    end
  end

  // Sends one byte; returns at the edge that accepts it.
  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = 0;
    while (!no_idle && $urandom_range(99) < 30) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_patch(b, last);
    sent_total++;
  endtask

  // Waits until every queued word has left, then for the pipeline to drain.
  task automatic drain();
    while (patched_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd4 * mcop_pkg::RegOffsetAdd) m_offset = data;
    else if (addr == 3'd4 * mcop_pkg::RegBufLen) m_buflen = data;
  endtask

  // Sends a whole buffer under the given settings.
  task automatic run_buffer(bytes_t img, logic [31:0] offset, logic [31:0] blen);
    in_ch.valid <= 1'b0;
    drain();
    write_reg(3'd4 * mcop_pkg::RegOffsetAdd, offset);
    write_reg(3'd4 * mcop_pkg::RegBufLen, blen);
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
    in_ch.valid <= 1'b0;
  endtask

  function automatic bytes_t be32(logic [31:0] v);
    return '{v[31:24], v[23:16], v[15:8], v[7:0]};
  endfunction

  function automatic bytes_t atom(logic [31:0] tag, bytes_t body);
    return {be32(body.size() + 8), be32(tag), body};
  endfunction

  function automatic bytes_t long_atom(logic [31:0] tag, bytes_t body);
    return {be32(1), be32(tag), be32(0), be32(body.size() + 16), body};
  endfunction

  function automatic bytes_t rand_bytes(int unsigned n);
    bytes_t q;
    repeat (n) q.push_back($urandom_range(255));
    return q;
  endfunction

  function automatic bytes_t offset_table(bit wide, int unsigned n);
    bytes_t q;
    q = {be32($urandom), be32(n)};
    repeat (n) q = {q, rand_bytes(wide ? 8 : 4)};
    return atom(wide ? mcop_pkg::TagCo64 : mcop_pkg::TagStco, q);
  endfunction

  // Random atom tree, mostly well formed.
  function automatic bytes_t rand_atom(int unsigned depth);
    bytes_t body;
    logic [31:0] tags[5];
    logic [31:0] tag;
    int unsigned kind;
    tags = '{mcop_pkg::TagMoov, mcop_pkg::TagTrak, mcop_pkg::TagMdia,
             mcop_pkg::TagMinf, mcop_pkg::TagStbl};
    kind = $urandom_range(9);
    if (depth < 4 && kind < 4) begin
      tag = tags[$urandom_range(4)];
      repeat ($urandom_range(1, 2)) body = {body, rand_atom(depth + 1)};
    end else if (kind < 7) begin
      return offset_table(kind == 6, $urandom_range(0, 3));
    end else begin
      tag = $urandom;
      body = rand_bytes($urandom_range(0, 6));
    end
    return ($urandom_range(4) == 0) ? long_atom(tag, body) : atom(tag, body);
  endfunction

  // A full track path with both table kinds, a skipped atom and carries.
  task automatic test_table_patch();
    bytes_t stbl, img;
    stbl = atom(mcop_pkg::TagStbl,
                {atom(mcop_pkg::TagStco, {be32(0), be32(2), be32(32'hffff_fffe),
                                          be32(32'h0000_0001)}),
                 atom(mcop_pkg::TagCo64, {be32(0), be32(1), be32(32'h0000_0000),
                                          be32(32'hffff_ffff)})});
    img = atom(mcop_pkg::TagMoov,
               atom(mcop_pkg::TagTrak,
                    atom(mcop_pkg::TagMdia, atom(mcop_pkg::TagMinf, stbl))));
    img = {img, atom(32'h6672_6565, '{8'h00, 8'hff, 8'h5a})};
    run_buffer(img, 32'hffff_ffff, img.size());
  endtask

  // Long size form and size zero running to the end of the parent.
  task automatic test_size_forms();
    bytes_t img;
    img = long_atom(mcop_pkg::TagMoov, {be32(0), be32(mcop_pkg::TagStco), be32(0),
                                        be32(1), be32(32'h8000_0000)});
    run_buffer(img, 32'h8000_0000, img.size());
  endtask

  // Each sticky error, with bytes after it passing unchanged.
  task automatic test_errors();
    bytes_t img, none;
    img = {be32(4), be32(32'h6a75_6e6b), 8'h11, 8'h22};
    run_buffer(img, 32'h1, img.size());
    img = {be32(32'hffff_fff0), be32(32'h6a75_6e6b), 8'h33};
    run_buffer(img, 32'h1, img.size());
    img = atom(mcop_pkg::TagStco, be32(0));
    run_buffer(img, 32'h1, img.size());
    img = atom(mcop_pkg::TagStco, {be32(0), be32(5), be32(7)});
    run_buffer(img, 32'h1, img.size());
    img = atom(32'h6a75_6e6b, none);
    repeat (11) img = atom(mcop_pkg::TagMoov, img);
    run_buffer(img, 32'h1, img.size());
    img = {be32(1), be32(mcop_pkg::TagMoov), 8'h00, 8'h01};
    run_buffer(img, 32'h1, img.size());
  endtask

  // Buffer ending inside an entry, short tails, bytes past the length.
  task automatic test_buffer_edges();
    bytes_t img;
    img = {be32(20), be32(mcop_pkg::TagCo64), be32(0), be32(1), 8'hde, 8'had, 8'hbe};
    run_buffer(img, 32'h5, 32'd40);
    img = {atom(32'h6a75_6e6b, '{8'h01}), 8'haa, 8'hbb, 8'hcc};
    run_buffer(img, 32'h5, img.size());
    img = offset_table(1'b0, 2);
    run_buffer(img, 32'h5, 32'd10);
    run_buffer(img, 32'h5, 32'd0);
    run_buffer('{8'hff}, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  // Random trees, some corrupted, with random and extreme settings.
  task automatic test_random_buffers();
    bytes_t img;
    int unsigned nbuf;
    logic [31:0] offs, blen;
    nbuf = 0;
    while (nbuf < 2 || sent_total < 280) begin
      // The second buffer runs without any idle cycles on either side.
      no_idle = (nbuf == 1);
      img.delete();
      repeat (no_idle ? 4 : $urandom_range(1, 3)) img = {img, rand_atom(0)};
      if ($urandom_range(6) == 0) img[$urandom_range(img.size() - 1)] = $urandom;
      case ($urandom_range(3))
        0: offs = 32'hffff_ffff;
        1: offs = $urandom_range(255);
        default: offs = $urandom;
      endcase
      blen = ($urandom_range(5) == 0) ? $urandom_range(img.size() + 8) : img.size();
      run_buffer(img, offs, blen);
      nbuf++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    m_offset = '0;
    m_buflen = '0;
    m_open = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_patch();
    test_size_forms();
    test_errors();
    test_buffer_edges();
    test_random_buffers();
    drain();
    if (mismatches == 0 && patched_words.size() == 0) begin
      $display("tb_movie_chunk_offset_patcher_unit: clean");
    end else begin
      $display("tb_movie_chunk_offset_patcher_unit: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("tb_movie_chunk_offset_patcher_unit: errors");
    $finish;
  end

endmodule
